[hdl/vdi_pkg.sv]
// Shared types, field widths and codes for the vertex dedup indexer.
package vdi_pkg;

	localparam int COORD_BITS = 16;
	localparam int SUM_BITS = COORD_BITS + 4;
	localparam int TOL_BITS = 12;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 12'd41;

	// command codes (s_axis_tuser)
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// status codes (m_axis_tuser)
	localparam logic [2:0] ST_APPEND = 3'd0;
	localparam logic [2:0] ST_MERGED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_BAD_INDEX = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [2:0][COORD_BITS-1:0] vec_in_t;
	typedef logic [2:0][SUM_BITS-1:0] vec_sum_t;

	// input payload without the entry index, x position in the low bits
	typedef struct packed {
		vec_in_t bitan;
		vec_in_t tan;
		vec_in_t nrm;
		logic [1:0][COORD_BITS-1:0] tex;
		vec_in_t pos;
	} in_fix_t;

	// one table entry; also the data part of a result item
	typedef struct packed {
		vec_sum_t bitan;
		vec_sum_t tan;
		vec_sum_t nrm;
		logic [1:0][COORD_BITS-1:0] tex;
		vec_in_t pos;
	} entry_t;

endpackage

[hdl/vdi_sat_vec.sv]
// Saturating adder for one three-component vector sum.
module vdi_sat_vec (
	input  vdi_pkg::vec_sum_t acc,
	input  vdi_pkg::vec_in_t  addend,
	output vdi_pkg::vec_sum_t total
);

	localparam int SW = vdi_pkg::SUM_BITS;
	localparam int CW = vdi_pkg::COORD_BITS;

	logic signed [SW:0] raw [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			raw[a] = $signed({acc[a][SW-1], acc[a]})
				+ $signed({{(SW + 1 - CW){addend[a][CW-1]}}, addend[a]});
			// clamp when the two top bits disagree
			if (raw[a][SW] != raw[a][SW-1]) begin
				total[a] = raw[a][SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			end else begin
				total[a] = raw[a][SW-1:0];
			end
		end
	end

endmodule

[hdl/vertex_dedup_indexer_unit.sv]
// Top level: vertex table with tolerance merge, scan sequencer and stream ports.
//
//   channel   | direction | tdata / tuser                      | handshake
//   s_axis    | in        | vertex payload / command           | tvalid, tready
//   m_axis    | out       | index, entry data, count / status  | tvalid, tready
//   cfg       | in        | match tolerance, 12 bits           | cfg_wr_en only
//
// Add with no match: one stored entry compared per cycle through the single read port
// of the table memory, then an append; a match at entry i stops the scan there and
// goes on to three vector sums and one write-back. A read passes through S_RDWAIT;
// a read with a bad index, clear and unused commands go straight to S_OUT.
// Reset empties the table through the entry count; the memory itself is not cleared.
// s_axis_tready is high only while idle; a result waits in the output register
// while m_axis_tready is low, and the next item may be taken meanwhile.
module vertex_dedup_indexer_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [vdi_pkg::TOL_BITS-1:0] cfg_wr_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v, normal_in, tangent_in, bitangent_in,
	// entry_index, zero fill
	input  logic [((14*vdi_pkg::COORD_BITS + $clog2(TABLE_DEPTH) + 7)/8)*8-1:0] s_axis_tdata,
	input  logic [1:0] s_axis_tuser, // command
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// vertex_index, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
	// normal_total, tangent_total, bitangent_total, entry_count_out, zero fill
	output logic [((5*vdi_pkg::COORD_BITS + 9*vdi_pkg::SUM_BITS + $clog2(TABLE_DEPTH)
		+ $clog2(TABLE_DEPTH+1) + 7)/8)*8-1:0] m_axis_tdata,
	output logic [2:0] m_axis_tuser // status
);

	localparam int C = vdi_pkg::COORD_BITS;
	localparam int SW = vdi_pkg::SUM_BITS;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IN_FIX_W = 14 * C;
	localparam int OUT_W = ((5*C + 9*SW + IW + CW + 7) / 8) * 8;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_MERGE = 3'd3;
	localparam logic [2:0] S_WRBACK = 3'd4;
	localparam logic [2:0] S_RDWAIT = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	function automatic vdi_pkg::vec_sum_t widen(input vdi_pkg::vec_in_t v);
		vdi_pkg::vec_sum_t r;
		for (int a = 0; a < 3; a++) begin
			r[a] = {{(SW - C){v[a][C-1]}}, v[a]};
		end
		return r;
	endfunction

	logic [2:0] state_q;
	logic [vdi_pkg::TOL_BITS-1:0] tol_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;
	logic pend_q;
	logic [IW-1:0] pend_idx_q;
	logic [IW-1:0] hit_idx_q;
	logic [1:0] k_q;
	vdi_pkg::vec_sum_t sum_q [3];
	vdi_pkg::in_fix_t in_q;
	logic [IW-1:0] res_idx_q;
	logic [2:0] res_status_q;
	logic res_data_q;

	logic out_valid_q;
	logic [IW-1:0] out_idx_q;
	logic [2:0] out_status_q;
	vdi_pkg::entry_t out_fix_q;
	logic [CW-1:0] out_cnt_q;

	vdi_pkg::entry_t mem_q [TABLE_DEPTH];
	vdi_pkg::entry_t rd_q;

	vdi_pkg::in_fix_t in_fix;
	logic [IW-1:0] in_eidx;
	logic accept;
	logic out_free;
	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	vdi_pkg::entry_t wr_data;
	logic signed [C:0] dlt [3];
	logic [C:0] mag [3];
	logic [2:0] near;
	logic hit;
	logic more;
	logic full;
	vdi_pkg::vec_sum_t mrg_acc;
	vdi_pkg::vec_in_t mrg_add;
	vdi_pkg::vec_sum_t mrg_total;

	assign in_fix = vdi_pkg::in_fix_t'(s_axis_tdata[IN_FIX_W-1:0]);
	assign in_eidx = s_axis_tdata[IN_FIX_W +: IW];
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign full = (count_q == CW'(TABLE_DEPTH));

	// distance test of the pending entry against the held position
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dlt[a] = $signed({in_q.pos[a][C-1], in_q.pos[a]})
				- $signed({rd_q.pos[a][C-1], rd_q.pos[a]});
			mag[a] = dlt[a][C] ? (C+1)'(-dlt[a]) : (C+1)'(dlt[a]);
			near[a] = mag[a] < (C+1)'(tol_q);
		end
	end

	assign hit = pend_q && (&near);
	assign more = (issue_q < count_q);

	always_comb begin
		case (k_q)
			2'd0: begin
				mrg_acc = rd_q.nrm;
				mrg_add = in_q.nrm;
			end
			2'd1: begin
				mrg_acc = rd_q.tan;
				mrg_add = in_q.tan;
			end
			default: begin
				mrg_acc = rd_q.bitan;
				mrg_add = in_q.bitan;
			end
		endcase
	end

	vdi_sat_vec u_sat (
		.acc    (mrg_acc),
		.addend (mrg_add),
		.total  (mrg_total)
	);

	// table read port: entry index on a read, scan address while scanning
	always_comb begin
		rd_en = 1'b0;
		rd_addr = issue_q[IW-1:0];
		if (state_q == S_IDLE) begin
			rd_addr = in_eidx;
			rd_en = accept && (s_axis_tuser == vdi_pkg::CMD_READ)
				&& (CW'(in_eidx) < count_q);
		end else if (state_q == S_SCAN) begin
			rd_en = !hit && more;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = hit_idx_q;
		wr_data.pos = in_q.pos;
		wr_data.tex = in_q.tex;
		wr_data.nrm = widen(in_q.nrm);
		wr_data.tan = widen(in_q.tan);
		wr_data.bitan = widen(in_q.bitan);
		if (state_q == S_APPEND) begin
			wr_en = !full;
			wr_addr = count_q[IW-1:0];
		end else if (state_q == S_WRBACK) begin
			wr_en = 1'b1;
			wr_data.pos = rd_q.pos;
			wr_data.tex = rd_q.tex;
			wr_data.nrm = sum_q[0];
			wr_data.tan = sum_q[1];
			wr_data.bitan = sum_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q <= vdi_pkg::TOL_RESET;
			count_q <= '0;
			issue_q <= '0;
			pend_q <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (s_axis_tuser)
							vdi_pkg::CMD_ADD: begin
								issue_q <= '0;
								pend_q <= 1'b0;
								state_q <= S_SCAN;
							end
							vdi_pkg::CMD_READ: begin
								state_q <= rd_en ? S_RDWAIT : S_OUT;
							end
							vdi_pkg::CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_OUT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						k_q <= '0;
						state_q <= S_MERGE;
					end else if (more) begin
						pend_q <= 1'b1;
						issue_q <= issue_q + 1'b1;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_MERGE: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd2) begin
						state_q <= S_WRBACK;
					end
				end
				S_WRBACK: begin
					state_q <= S_OUT;
				end
				S_RDWAIT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// held item and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_fix;
			if (s_axis_tuser == vdi_pkg::CMD_READ) begin
				res_idx_q <= in_eidx;
				res_data_q <= rd_en;
				res_status_q <= rd_en ? vdi_pkg::ST_DONE : vdi_pkg::ST_BAD_INDEX;
			end else begin
				res_idx_q <= '0;
				res_data_q <= 1'b0;
				res_status_q <= vdi_pkg::ST_DONE;
			end
		end
		if (state_q == S_SCAN) begin
			if (rd_en) begin
				pend_idx_q <= issue_q[IW-1:0];
			end
			if (hit) begin
				hit_idx_q <= pend_idx_q;
			end
		end
		if (state_q == S_MERGE) begin
			sum_q[k_q] <= mrg_total;
		end
		if (state_q == S_APPEND) begin
			res_idx_q <= full ? '0 : count_q[IW-1:0];
			res_status_q <= full ? vdi_pkg::ST_FULL : vdi_pkg::ST_APPEND;
		end
		if (state_q == S_WRBACK) begin
			res_idx_q <= hit_idx_q;
			res_status_q <= vdi_pkg::ST_MERGED;
		end
		if (state_q == S_OUT && out_free) begin
			out_idx_q <= res_idx_q;
			out_status_q <= res_status_q;
			out_fix_q <= res_data_q ? rd_q : '0;
			out_cnt_q <= count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_status_q;
	assign m_axis_tdata = OUT_W'({out_cnt_q, out_fix_q, out_idx_q});

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CW'(wr_addr) <= count_q) && (CW'(wr_addr) < CW'(TABLE_DEPTH)))
		else $error("table write outside the filled range");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && pend_q) |-> (CW'(pend_idx_q) < count_q))
		else $error("scan compares an entry beyond the count");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == vdi_pkg::ST_APPEND)
		|-> (out_cnt_q == CW'(out_idx_q) + 1'b1))
		else $error("appended index does not match the new count");

	a_merge_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE && k_q == 2'd0) |-> $past(state_q) == S_SCAN)
		else $error("merge entered without a scan hit");

endmodule

[bench/vertex_dedup_indexer_unit_tb.sv]
// Testbench for the vertex dedup indexer: directed and random streams against a predictor.
`timescale 1ns / 100ps

module vertex_dedup_indexer_unit_tb;

	localparam int TABLE_SLOTS = 256;
	localparam int IN_W = (($bits(vdi_pkg::in_fix_t) + 8 + 7) / 8) * 8;
	localparam int OUT_W = ((8 + $bits(vdi_pkg::entry_t) + 9 + 7) / 8) * 8;
	localparam int CNT_LSB = 8 + $bits(vdi_pkg::entry_t);
	localparam int SUM_MAX = (1 << (vdi_pkg::SUM_BITS - 1)) - 1;
	localparam int SUM_MIN = -(1 << (vdi_pkg::SUM_BITS - 1));
	localparam int LIMIT_CYCLES = 2000000;
	localparam int LONG_HOLD = 800;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam vdi_pkg::vec_in_t VEC_MAX = {3{16'h7FFF}};
	localparam vdi_pkg::vec_in_t VEC_MIN = {3{16'h8000}};
	localparam vdi_pkg::vec_in_t VEC_ONES = '1;
	localparam vdi_pkg::vec_in_t VEC_ZERO = '0;

	typedef struct {
		logic [1:0] cmd;
		vdi_pkg::in_fix_t fx;
		logic [7:0] eidx;
	} vertex_cmd_t;

	typedef struct {
		logic [7:0] vidx;
		logic [2:0] st;
		vdi_pkg::entry_t data;
		logic [8:0] cnt;
	} vertex_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [vdi_pkg::TOL_BITS-1:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	vertex_dedup_indexer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	int tol_now = vdi_pkg::TOL_RESET;
	int stored = 0;
	vdi_pkg::vec_in_t tab_pos [TABLE_SLOTS];
	logic [1:0][vdi_pkg::COORD_BITS-1:0] tab_tex [TABLE_SLOTS];
	vdi_pkg::vec_sum_t tab_nrm [TABLE_SLOTS];
	vdi_pkg::vec_sum_t tab_tan [TABLE_SLOTS];
	vdi_pkg::vec_sum_t tab_bitan [TABLE_SLOTS];

	vertex_cmd_t vertex_cmd_q[$];
	vertex_reply_t expected_replies[$];
	vdi_pkg::vec_in_t pos_pool[$];

	int fail_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit in_flight = 1'b0;
	logic in_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int long_hold_req = 0;
	int long_hold_done = 0;

	function automatic bit close_to(vdi_pkg::vec_in_t a, vdi_pkg::vec_in_t b);
		int d;
		for (int k = 0; k < 3; k++) begin
			d = int'($signed(a[k])) - int'($signed(b[k]));
			if (d < 0)
				d = -d;
			if (d >= tol_now)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic vdi_pkg::vec_sum_t widen(vdi_pkg::vec_in_t v);
		vdi_pkg::vec_sum_t r;
		for (int k = 0; k < 3; k++)
			r[k] = {{(vdi_pkg::SUM_BITS - vdi_pkg::COORD_BITS){v[k][vdi_pkg::COORD_BITS-1]}},
				v[k]};
		return r;
	endfunction

	function automatic vdi_pkg::vec_sum_t sum_sat(vdi_pkg::vec_sum_t s, vdi_pkg::vec_in_t v);
		vdi_pkg::vec_sum_t r;
		int a;
		int b;
		int t;
		for (int k = 0; k < 3; k++) begin
			a = $signed(s[k]);
			b = $signed(v[k]);
			t = a + b;
			if (t > SUM_MAX)
				t = SUM_MAX;
			if (t < SUM_MIN)
				t = SUM_MIN;
			r[k] = t[vdi_pkg::SUM_BITS-1:0];
		end
		return r;
	endfunction

	// work out the reply to one accepted item and update the table
	function automatic void index_vertex(logic [1:0] cmd, logic [IN_W-1:0] payload);
		vdi_pkg::in_fix_t v;
		logic [7:0] eidx;
		vertex_reply_t r;
		int hit;
		v = payload[$bits(vdi_pkg::in_fix_t)-1:0];
		eidx = payload[$bits(vdi_pkg::in_fix_t)+7:$bits(vdi_pkg::in_fix_t)];
		r.vidx = '0;
		r.st = vdi_pkg::ST_DONE;
		r.data = '0;
		hit = -1;
		case (cmd)
			vdi_pkg::CMD_ADD: begin
				for (int k = 0; k < stored && hit < 0; k++)
					if (close_to(v.pos, tab_pos[k]))
						hit = k;
				if (hit >= 0) begin
					tab_nrm[hit] = sum_sat(tab_nrm[hit], v.nrm);
					tab_tan[hit] = sum_sat(tab_tan[hit], v.tan);
					tab_bitan[hit] = sum_sat(tab_bitan[hit], v.bitan);
					r.vidx = 8'(hit);
					r.st = vdi_pkg::ST_MERGED;
				end else if (stored >= TABLE_SLOTS) begin
					r.st = vdi_pkg::ST_FULL;
				end else begin
					tab_pos[stored] = v.pos;
					tab_tex[stored] = v.tex;
					tab_nrm[stored] = widen(v.nrm);
					tab_tan[stored] = widen(v.tan);
					tab_bitan[stored] = widen(v.bitan);
					r.vidx = 8'(stored);
					r.st = vdi_pkg::ST_APPEND;
					stored++;
				end
			end
			vdi_pkg::CMD_READ: begin
				r.vidx = eidx;
				if (eidx >= stored) begin
					r.st = vdi_pkg::ST_BAD_INDEX;
				end else begin
					r.data.pos = tab_pos[eidx];
					r.data.tex = tab_tex[eidx];
					r.data.nrm = tab_nrm[eidx];
					r.data.tan = tab_tan[eidx];
					r.data.bitan = tab_bitan[eidx];
				end
			end
			vdi_pkg::CMD_CLEAR: begin
				stored = 0;
			end
			default: begin
			end
		endcase
		r.cnt = 9'(stored);
		expected_replies = {expected_replies, r};
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_reply(logic [OUT_W-1:0] td, logic [2:0] tu);
		vertex_reply_t want;
		vdi_pkg::entry_t got;
		if (expected_replies.size() == 0) begin
			$error("result item with none expected: index %0d status %0d", td[7:0], tu);
			fail_count++;
		end else begin
			want = expected_replies.pop_front();
			got = td[CNT_LSB-1:8];
			check_field("vertex_index", 64'(want.vidx), 64'(td[7:0]));
			check_field("status", 64'(want.st), 64'(tu));
			check_field("out_pos_x", 64'(want.data.pos[0]), 64'(got.pos[0]));
			check_field("out_pos_y", 64'(want.data.pos[1]), 64'(got.pos[1]));
			check_field("out_pos_z", 64'(want.data.pos[2]), 64'(got.pos[2]));
			check_field("out_tex_u", 64'(want.data.tex[0]), 64'(got.tex[0]));
			check_field("out_tex_v", 64'(want.data.tex[1]), 64'(got.tex[1]));
			check_field("normal_total", 64'(want.data.nrm), 64'(got.nrm));
			check_field("tangent_total", 64'(want.data.tan), 64'(got.tan));
			check_field("bitangent_total", 64'(want.data.bitan), 64'(got.bitan));
			check_field("entry_count_out", 64'(want.cnt), 64'(td[CNT_LSB+8:CNT_LSB]));
		end
	endfunction

	function automatic vdi_pkg::vec_in_t rand_vec();
		vdi_pkg::vec_in_t v;
		case ($urandom_range(0, 3))
			0: v = 48'({$urandom, $urandom});
			1: v = VEC_MAX;
			2: v = VEC_MIN;
			default: begin
				for (int k = 0; k < 3; k++)
					v[k] = 16'(int'($urandom_range(0, 64)) - 32);
			end
		endcase
		return v;
	endfunction

	function automatic vertex_cmd_t make_vertex_cmd(bit adds_only, bit allow_clear);
		vertex_cmd_t c;
		vdi_pkg::vec_in_t base;
		int r;
		int jit;
		r = $urandom_range(0, 99);
		if (adds_only || r < 72)
			c.cmd = vdi_pkg::CMD_ADD;
		else if (r < 92)
			c.cmd = vdi_pkg::CMD_READ;
		else if (r < 97)
			c.cmd = allow_clear ? vdi_pkg::CMD_CLEAR : vdi_pkg::CMD_ADD;
		else
			c.cmd = CMD_UNUSED;
		// land near an earlier vertex half the time, straddling the tolerance
		if (pos_pool.size() > 0 && $urandom_range(0, 1)) begin
			base = pos_pool[$urandom_range(0, pos_pool.size() - 1)];
			for (int k = 0; k < 3; k++) begin
				jit = int'($urandom_range(0, 2 * tol_now + 4)) - (tol_now + 2);
				c.fx.pos[k] = base[k] + jit[vdi_pkg::COORD_BITS-1:0];
			end
		end else begin
			c.fx.pos = 48'({$urandom, $urandom});
		end
		c.fx.tex = $urandom;
		c.fx.nrm = rand_vec();
		c.fx.tan = rand_vec();
		c.fx.bitan = rand_vec();
		if ($urandom_range(0, 9) < 7)
			c.eidx = (stored > 255) ? 8'd255 : 8'($urandom_range(0, stored));
		else
			c.eidx = 8'($urandom);
		if (c.cmd == vdi_pkg::CMD_ADD) begin
			pos_pool = {pos_pool, c.fx.pos};
			if (pos_pool.size() > 64)
				void'(pos_pool.pop_front());
		end
		return c;
	endfunction

	function automatic vertex_cmd_t add_cmd(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			vdi_pkg::vec_in_t n, vdi_pkg::vec_in_t t, vdi_pkg::vec_in_t b);
		vertex_cmd_t c;
		c.cmd = vdi_pkg::CMD_ADD;
		c.fx.pos = {z, y, x};
		c.fx.tex = {16'h7FFF, 16'h8000};
		c.fx.nrm = n;
		c.fx.tan = t;
		c.fx.bitan = b;
		c.eidx = 8'hFF;
		return c;
	endfunction

	function automatic vertex_cmd_t plain_cmd(logic [1:0] cmd, logic [7:0] eidx);
		vertex_cmd_t c;
		c.cmd = cmd;
		c.fx = '0;
		c.eidx = eidx;
		return c;
	endfunction

	task automatic queue_cmd(vertex_cmd_t c);
		while (vertex_cmd_q.size() >= 4)
			@(posedge clk);
		vertex_cmd_q = {vertex_cmd_q, c};
	endtask

	task automatic wait_idle();
		while (vertex_cmd_q.size() != 0 || in_flight || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_tolerance(int value);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[vdi_pkg::TOL_BITS-1:0];
		tol_now = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_run(int n, bit adds_only, bit allow_clear);
		for (int i = 0; i < n; i++)
			queue_cmd(make_vertex_cmd(adds_only, allow_clear));
	endtask

	// sender: present one item at a time, random gaps between items
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken)
				in_flight = 1'b0;
			if (in_flight) begin
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (vertex_cmd_q.size() > 0) begin
				s_axis_tdata <= {vertex_cmd_q[0].eidx, vertex_cmd_q[0].fx};
				s_axis_tuser <= vertex_cmd_q[0].cmd;
				void'(vertex_cmd_q.pop_front());
				in_flight = 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 15);
			end
			s_axis_tvalid <= in_flight;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold_done != long_hold_req) begin
				long_hold_done = long_hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 15);
			end
		end
	end

	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			index_vertex(s_axis_tuser, s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_reply(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: corner positions, tolerance edge, lowest-index match, saturation
		queue_cmd(add_cmd(16'h8000, 16'h7FFF, 16'h0000, VEC_MAX, VEC_MIN, VEC_ZERO));
		queue_cmd(add_cmd(16'h8028, 16'h7FD7, 16'h0028, VEC_MAX, VEC_MIN, VEC_ONES));
		queue_cmd(add_cmd(16'h8029, 16'h7FFF, 16'h0000, VEC_MAX, VEC_MIN, VEC_ZERO));
		// near both stored entries: merge into the lower one until the sums clamp
		repeat (15)
			queue_cmd(add_cmd(16'h8014, 16'h7FFF, 16'hFFD8, VEC_MAX, VEC_MIN, VEC_ONES));
		queue_cmd(plain_cmd(vdi_pkg::CMD_READ, 8'd0));
		queue_cmd(plain_cmd(vdi_pkg::CMD_READ, 8'd1));
		queue_cmd(plain_cmd(vdi_pkg::CMD_READ, 8'd2));
		queue_cmd(plain_cmd(vdi_pkg::CMD_READ, 8'd255));
		queue_cmd(plain_cmd(CMD_UNUSED, 8'd7));
		queue_cmd(plain_cmd(vdi_pkg::CMD_CLEAR, 8'd0));
		queue_cmd(plain_cmd(vdi_pkg::CMD_READ, 8'd0));
		queue_cmd(add_cmd(16'h0000, 16'h0000, 16'h0000, VEC_ZERO, VEC_ZERO, VEC_ZERO));

		// widest tolerance, with one long receiver hold-off
		set_tolerance(4095);
		random_run(150, 1'b0, 1'b1);
		long_hold_req++;
		random_run(300, 1'b0, 1'b1);

		// zero tolerance: fill the table past full
		set_tolerance(0);
		queue_cmd(plain_cmd(vdi_pkg::CMD_CLEAR, 8'd0));
		random_run(262, 1'b1, 1'b0);
		set_tolerance(vdi_pkg::TOL_RESET);
		random_run(70, 1'b0, 1'b0);

		set_tolerance($urandom_range(1, 4094));
		queue_cmd(plain_cmd(vdi_pkg::CMD_CLEAR, 8'd0));
		random_run(250, 1'b0, 1'b1);
		// drain before going on
		wait_idle();
		random_run(250, 1'b0, 1'b1);

		set_tolerance($urandom_range(0, 4095));
		calm = 1'b1;
		random_run(200, 1'b0, 1'b1);

		wait_idle();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
hdl/vdi_pkg.sv
hdl/vdi_sat_vec.sv
hdl/vertex_dedup_indexer_unit.sv
bench/vertex_dedup_indexer_unit_tb.sv
